### rtl/scored_entry_pruner_core_defines.svh
// ----------------------------------------------------------------------------
// scored_entry_pruner_core_defines.svh
// Assertion macros used by the pruner core RTL.
// ----------------------------------------------------------------------------
`ifndef SCORED_ENTRY_PRUNER_CORE_DEFINES_SVH
`define SCORED_ENTRY_PRUNER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SEP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SEP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sep_pkg.sv
// ----------------------------------------------------------------------------
// sep_pkg
// Types and constants of the scored entry pruner.
// ----------------------------------------------------------------------------
package sep_pkg;

    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int SCORE_W = 18;
    localparam int ADDR_W  = 5;

    // register indexes
    localparam logic [2:0] REG_MAX_KEPT    = 3'd0;
    localparam logic [2:0] REG_KEEP_STRUCT = 3'd1;
    localparam logic [2:0] REG_MIN_WEIGHT  = 3'd2;
    localparam logic [2:0] REG_MIN_QUALITY = 3'd3;
    localparam logic [2:0] REG_LONG_LIMIT  = 3'd4;

    // Q10.8 constants
    localparam logic signed [SCORE_W-1:0] BONUS_HI      = 18'sd77;
    localparam logic signed [SCORE_W-1:0] BONUS_MID     = 18'sd51;
    localparam logic signed [SCORE_W-1:0] BONUS_LO      = 18'sd26;
    localparam logic signed [SCORE_W-1:0] PEN_LONG      = 18'sd51;
    localparam logic signed [SCORE_W-1:0] PEN_EMPTY     = 18'sd256;

    typedef struct packed {
        logic [6:0]         max_kept;
        logic               keep_structural;
        logic signed [15:0] min_weight;
        logic signed [15:0] min_quality;
        logic [9:0]         long_action_limit;
    } t_cfg;

    typedef struct packed {
        logic                      valid;
        logic signed [SCORE_W-1:0] score;
        logic [IDX_W-1:0]          idx;
        logic                      strct;   // always kept
        logic                      pass;    // passes weight/quality/empty filters
    } t_cell;

    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
    } t_cell_ctl;

    function automatic logic signed [SCORE_W-1:0] rel_bonus(input logic [2:0] rel);
        logic signed [SCORE_W-1:0] b;
        case (rel)
            3'd0, 3'd1: b = BONUS_HI;
            3'd2, 3'd3: b = BONUS_MID;
            3'd4:       b = BONUS_LO;
            default:    b = '0;
        endcase
        return b;
    endfunction

endpackage

### rtl/sep_ifs.sv
// ----------------------------------------------------------------------------
// sep_ifs
// Valid/ready channels of the pruner: entry input and result output.
// ----------------------------------------------------------------------------
interface sep_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] edge_weight;
    logic               has_solution;
    logic signed [15:0] solution_score;
    logic [2:0]         relation;
    logic [9:0]         action_count;
    logic               last_entry;

    modport source (output valid, edge_weight, has_solution, solution_score,
                    relation, action_count, last_entry, input ready);
    modport sink   (input valid, edge_weight, has_solution, solution_score,
                    relation, action_count, last_entry, output ready);
endinterface

interface sep_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] entry_index;
    logic       keep;
    logic [5:0] new_index;
    logic [6:0] removed_count;
    logic       overflow;
    logic       last_result;

    modport source (output valid, entry_index, keep, new_index, removed_count,
                    overflow, last_result, input ready);
    modport sink   (input valid, entry_index, keep, new_index, removed_count,
                    overflow, last_result, output ready);
endinterface

### rtl/sep_regs.sv
// ----------------------------------------------------------------------------
// sep_regs
// APB configuration registers of the pruner.
// ----------------------------------------------------------------------------
module sep_regs
    import sep_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);
    t_cfg       r_cfg;
    logic [2:0] w_sel;

    assign w_sel  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_kept          <= 7'd32;
            r_cfg.keep_structural   <= 1'b1;
            r_cfg.min_weight        <= '0;
            r_cfg.min_quality       <= '0;
            r_cfg.long_action_limit <= 10'd22;
        end else if (psel && penable && pwrite) begin
            case (w_sel)
                REG_MAX_KEPT:    r_cfg.max_kept          <= pwdata[6:0];
                REG_KEEP_STRUCT: r_cfg.keep_structural   <= pwdata[0];
                REG_MIN_WEIGHT:  r_cfg.min_weight        <= pwdata[15:0];
                REG_MIN_QUALITY: r_cfg.min_quality       <= pwdata[15:0];
                REG_LONG_LIMIT:  r_cfg.long_action_limit <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            REG_MAX_KEPT:    prdata = {25'd0, r_cfg.max_kept};
            REG_KEEP_STRUCT: prdata = {31'd0, r_cfg.keep_structural};
            REG_MIN_WEIGHT:  prdata = {16'd0, r_cfg.min_weight};
            REG_MIN_QUALITY: prdata = {16'd0, r_cfg.min_quality};
            REG_LONG_LIMIT:  prdata = {22'd0, r_cfg.long_action_limit};
            default:         prdata = '0;
        endcase
    end
endmodule

### rtl/sep_cell.sv
// ----------------------------------------------------------------------------
// sep_cell
// One slot of the sorted chain: insert on load, shift toward head on walk.
// ----------------------------------------------------------------------------
module sep_cell
    import sep_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_cell     i_new,
    input  t_cell     i_prev,
    input  logic      i_prev_stay,
    input  t_cell     i_next,
    output t_cell     o_cell,
    output logic      o_stay
);
    t_cell r_c;
    t_cell n_c;

    // equal scores stay ahead, so earlier entries win ties
    assign o_stay = r_c.valid && ($signed(r_c.score) >= $signed(i_new.score));
    assign o_cell = r_c;

    always_comb begin
        n_c = r_c;
        if (i_ctl.clear) begin
            n_c.valid = 1'b0;
        end else if (i_ctl.load) begin
            if (!o_stay) n_c = i_prev_stay ? i_new : i_prev;
        end else if (i_ctl.shift) begin
            n_c = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.valid <= 1'b0;
        end else begin
            r_c.valid <= n_c.valid;
        end
        r_c.score <= n_c.score;
        r_c.idx   <= n_c.idx;
        r_c.strct <= n_c.strct;
        r_c.pass  <= n_c.pass;
    end
endmodule

### rtl/scored_entry_pruner_core.sv
// ----------------------------------------------------------------------------
// scored_entry_pruner_core
// Scores entries, sorts them in a chain of cells, prunes, emits keep results.
// ----------------------------------------------------------------------------
// channel   dir  handshake           content
// i_in      in   valid/ready         one entry per transaction
// o_res     out  valid/ready         one result per stored entry
// APB       in   psel/penable/pready configuration registers
//
// Load: one entry per cycle, inserted into the sorted chain as it arrives.
// Prune walk (only when the set exceeds max_kept): one chain cell per cycle
// popped off the head. Emit: one result per cycle while o_res is ready.
// Input is stalled during walk and emit; o_res holds while ready is low.
// Reset is synchronous, active low, and clears all control state at once.
`include "scored_entry_pruner_core_defines.svh"

module scored_entry_pruner_core
    import sep_pkg::*;
#(
    parameter int MAX_EDGES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sep_in_if.sink            i_in,
    sep_out_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    typedef enum logic [1:0] {S_LOAD, S_WALK, S_EMIT} t_state;

    t_cfg  w_cfg;
    t_state r_state;

    sep_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(w_cfg)
    );

    logic [CNT_W-1:0]     r_count, r_kept, r_walk;
    logic                 r_ovf, r_all;
    logic [MAX_EDGES-1:0] r_flags;
    logic [IW-1:0]        r_oi;
    logic [IDX_W-1:0]     r_nid;

    logic r_ov;
    logic [5:0] r_o_idx, r_o_nidx;
    logic       r_o_keep, r_o_ovf, r_o_last;
    logic [6:0] r_o_rem;

    // ---- scoring of the incoming entry
    logic signed [SCORE_W-1:0] w_score;
    logic                      w_pass, w_strct, w_acc, w_store, w_full;
    t_cell                     w_new;
    t_cell_ctl                 w_ctl;

    always_comb begin
        w_score = SCORE_W'(i_in.edge_weight) + rel_bonus(i_in.relation);
        if (i_in.has_solution) begin
            w_score = w_score + SCORE_W'(i_in.solution_score >>> 1);
            if (i_in.action_count > w_cfg.long_action_limit) w_score = w_score - PEN_LONG;
            if (i_in.action_count == '0) w_score = w_score - PEN_EMPTY;
        end
    end

    assign w_strct = w_cfg.keep_structural && (i_in.relation <= 3'd2);
    assign w_pass  = (i_in.edge_weight >= w_cfg.min_weight)
                   && !(i_in.has_solution && (i_in.solution_score < w_cfg.min_quality))
                   && !(i_in.has_solution && (i_in.action_count == '0));

    assign w_new = '{valid: 1'b1, score: w_score, idx: IDX_W'(r_count),
                     strct: w_strct, pass: w_pass};

    assign i_in.ready = (r_state == S_LOAD);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CNT_W'(MAX_EDGES));
    assign w_store    = w_acc && !w_full;

    // ---- sorted chain
    t_cell w_cell [MAX_EDGES];
    logic  w_stay [MAX_EDGES];
    t_cell w_head;
    logic  w_emit, w_emit_last, w_head_keep;

    assign w_ctl.load  = w_store;
    assign w_ctl.shift = (r_state == S_WALK);
    assign w_ctl.clear = w_emit_last;

    for (genvar g = 0; g < MAX_EDGES; g++) begin : g_chain
        t_cell w_prev, w_next;
        logic  w_pstay;
        if (g == 0) begin : g_head
            assign w_prev  = w_new;
            assign w_pstay = 1'b1;
        end else begin : g_body
            assign w_prev  = w_cell[g-1];
            assign w_pstay = w_stay[g-1];
        end
        if (g == MAX_EDGES - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell[g+1];
        end
        sep_cell u_cell (
            .i_clk, .i_rst_n, .i_ctl(w_ctl), .i_new(w_new), .i_prev(w_prev),
            .i_prev_stay(w_pstay), .i_next(w_next), .o_cell(w_cell[g]),
            .o_stay(w_stay[g])
        );
    end

    assign w_head      = w_cell[0];
    assign w_head_keep = w_head.valid
                       && (w_head.strct || (w_head.pass && (r_kept < w_cfg.max_kept)));

    // ---- emit
    logic w_keep_i;
    assign w_emit      = (r_state == S_EMIT) && (!r_ov || o_res.ready);
    assign w_emit_last = w_emit && ({1'b0, IDX_W'(r_oi)} == r_count - CNT_W'(1));
    assign w_keep_i    = r_all || r_flags[r_oi];

    logic [CNT_W-1:0] w_n_total;
    assign w_n_total = r_count + CNT_W'(w_store);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_kept  <= '0;
            r_walk  <= '0;
            r_ovf   <= 1'b0;
            r_all   <= 1'b0;
            r_flags <= '0;
            r_oi    <= '0;
            r_nid   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_emit) r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        r_count <= w_n_total;
                        if (w_full) r_ovf <= 1'b1;
                        if (i_in.last_entry) begin
                            r_oi  <= '0;
                            r_nid <= '0;
                            r_walk <= '0;
                            if (w_n_total > w_cfg.max_kept) begin
                                r_kept  <= '0;
                                r_state <= S_WALK;
                            end else begin
                                r_kept  <= w_n_total;
                                r_all   <= 1'b1;
                                r_state <= S_EMIT;
                            end
                        end
                    end
                end
                S_WALK: begin
                    if (w_head_keep) begin
                        r_flags[w_head.idx[IW-1:0]] <= 1'b1;
                        r_kept <= r_kept + CNT_W'(1);
                    end
                    r_walk <= r_walk + CNT_W'(1);
                    if (r_walk == r_count - CNT_W'(1)) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_o_idx  <= IDX_W'(r_oi);
                        r_o_keep <= w_keep_i;
                        r_o_nidx <= w_keep_i ? r_nid : '0;
                        r_o_rem  <= r_count - r_kept;
                        r_o_ovf  <= r_ovf;
                        r_o_last <= w_emit_last;
                        r_nid    <= r_nid + IDX_W'(w_keep_i);
                        r_oi     <= r_oi + IW'(1);
                        // flags are cleared one by one as they are read out
                        r_flags[r_oi] <= 1'b0;
                        if (w_emit_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_all   <= 1'b0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.entry_index   = r_o_idx;
    assign o_res.keep          = r_o_keep;
    assign o_res.new_index     = r_o_nidx;
    assign o_res.removed_count = r_o_rem;
    assign o_res.overflow      = r_o_ovf;
    assign o_res.last_result   = r_o_last;

    `SEP_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_EDGES), "entry count overran")
    `SEP_ASSERT_NOW(a_kept_bound, r_state == S_EMIT, r_kept <= r_count, "kept exceeds set size")
    `SEP_ASSERT_NOW(a_walk_head, r_state == S_WALK, w_head.valid, "walk reached empty cell")
    `SEP_ASSERT_NXT(a_emit_clear, w_emit_last, r_count == '0 && r_flags == '0, "set not cleared")
endmodule

### bench/tb_scored_entry_pruner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scored_entry_pruner_core
// Self-checking bench: random entry sets through the pruner, keep decisions
// predicted in the bench and compared per result, across register settings.
// ----------------------------------------------------------------------------
module tb_scored_entry_pruner_core;
    import sep_pkg::*;

    typedef struct {
        logic signed [15:0] weight;
        logic               has_sol;
        logic signed [15:0] sol;
        logic [2:0]         rel;
        logic [9:0]         actions;
        logic               last;
    } t_entry;

    typedef struct {
        logic [5:0] idx;
        logic       keep;
        logic [5:0] new_idx;
        logic [6:0] removed;
        logic       ovf;
        logic       last;
    } t_verdict;

    class keep_scoreboard;
        t_cfg        cfg;
        t_entry      held[$];
        logic        ovf_seen;
        t_verdict    pending[$];
        int          errors;

        function automatic logic signed [17:0] rank(t_entry e);
            logic signed [17:0] s;
            s = e.weight;
            if (e.has_sol) s = s + (18'(e.sol) >>> 1);
            case (e.rel)
                3'd0, 3'd1: s = s + 18'sd77;
                3'd2, 3'd3: s = s + 18'sd51;
                3'd4:       s = s + 18'sd26;
                default: ;
            endcase
            if (e.has_sol) begin
                if (e.actions > cfg.long_action_limit) s = s - 18'sd51;
                if (e.actions == 0) s = s - 18'sd256;
            end
            return s;
        endfunction

        function void note_entry(t_entry e);
            int n, kept, nid, j, k;
            int order[$];
            logic signed [17:0] sc[$];
            logic kf[64];
            if (held.size() < 64) held = {held, e};
            else ovf_seen = 1;
            if (!e.last) return;
            n = held.size();
            kept = 0;
            foreach (kf[i]) kf[i] = 0;
            foreach (held[i]) sc = {sc, rank(held[i])};
            if (n <= cfg.max_kept) begin
                for (int i = 0; i < n; i++) kf[i] = 1;
                kept = n;
            end else begin
                for (int i = 0; i < n; i++) begin
                    j = 0;
                    while (j < order.size() && sc[order[j]] >= sc[i]) j++;
                    order.insert(j, i);
                end
                for (j = 0; j < n; j++) begin
                    k = order[j];
                    if (cfg.keep_structural && held[k].rel <= 2) begin
                        kf[k] = 1; kept++; continue;
                    end
                    if (held[k].weight < cfg.min_weight) continue;
                    if (held[k].has_sol && held[k].sol < cfg.min_quality) continue;
                    if (held[k].has_sol && held[k].actions == 0) continue;
                    if (kept < cfg.max_kept) begin
                        kf[k] = 1; kept++;
                    end
                end
            end
            nid = 0;
            for (int i = 0; i < n; i++) begin
                t_verdict v;
                v.idx = 6'(i);
                v.keep = kf[i];
                v.new_idx = kf[i] ? 6'(nid) : 6'd0;
                if (kf[i]) nid++;
                v.removed = 7'(n - kept);
                v.ovf = ovf_seen;
                v.last = (i == n - 1);
                pending = {pending, v};
            end
            held.delete();
            ovf_seen = 0;
        endfunction

        function void check_result(t_verdict a);
            t_verdict x;
            if (pending.size() == 0) begin
                $display("%0t unexpected result idx=%0d", $time, a.idx);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (a.idx != x.idx || a.keep != x.keep || a.new_idx != x.new_idx ||
                a.removed != x.removed || a.ovf != x.ovf || a.last != x.last) begin
                $display("%0t mismatch exp idx=%0d keep=%0d new=%0d rem=%0d ovf=%0d last=%0d",
                         $time, x.idx, x.keep, x.new_idx, x.removed, x.ovf, x.last);
                $display("%0t          got idx=%0d keep=%0d new=%0d rem=%0d ovf=%0d last=%0d",
                         $time, a.idx, a.keep, a.new_idx, a.removed, a.ovf, a.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    sep_in_if  ent_ch ();
    sep_out_if res_ch ();

    scored_entry_pruner_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(ent_ch.sink), .o_res(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    keep_scoreboard sb;
    int  hold_off = 0;      // long receiver stall, in cycles
    bit  sink_random = 1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[scored_entry_pruner_core] ERROR");
        $finish;
    end

    initial begin
        ent_ch.valid = 0; ent_ch.edge_weight = 0; ent_ch.has_solution = 0;
        ent_ch.solution_score = 0; ent_ch.relation = 0; ent_ch.action_count = 0;
        ent_ch.last_entry = 0;
        res_ch.ready = 0;
    end

    // result receiver
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            t_verdict a;
            a.idx = res_ch.entry_index; a.keep = res_ch.keep;
            a.new_idx = res_ch.new_index; a.removed = res_ch.removed_count;
            a.ovf = res_ch.overflow; a.last = res_ch.last_result;
            sb.check_result(a);
        end
    end

    initial begin : sink_proc
        int w;
        @(posedge i_rst_n);
        forever begin
            if (hold_off > 0) begin
                res_ch.ready <= 0;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end
            w = sink_random ? $urandom_range(0, 9) : 0;
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
                res_ch.ready <= 0;
                repeat (w) @(posedge i_clk);
            end
            res_ch.ready <= 1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    // registers change only while no set is in flight
    task automatic reg_write(input logic [2:0] ridx, input logic [31:0] val);
        ent_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(ridx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (ridx)
            REG_MAX_KEPT:    sb.cfg.max_kept = val[6:0];
            REG_KEEP_STRUCT: sb.cfg.keep_structural = val[0];
            REG_MIN_WEIGHT:  sb.cfg.min_weight = val[15:0];
            REG_MIN_QUALITY: sb.cfg.min_quality = val[15:0];
            default:         sb.cfg.long_action_limit = val[9:0];
        endcase
    endtask

    task automatic send_entry(input t_entry e, input bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 9) : 0;
        if (w > 0) begin
            ent_ch.valid <= 0;
            repeat (w) @(posedge i_clk);
        end
        ent_ch.valid <= 1;
        ent_ch.edge_weight <= e.weight; ent_ch.has_solution <= e.has_sol;
        ent_ch.solution_score <= e.sol; ent_ch.relation <= e.rel;
        ent_ch.action_count <= e.actions; ent_ch.last_entry <= e.last;
        @(posedge i_clk);
        while (!ent_ch.ready) @(posedge i_clk);
        sb.note_entry(e);
    endtask

    task automatic idle_input();
        ent_ch.valid <= 0;
    endtask

    task automatic drain();
        idle_input();
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_entry rand_entry(input bit last, input bit extremes);
        t_entry e;
        e.weight  = extremes ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
        e.has_sol = $urandom_range(0, 3) != 0;
        e.sol     = extremes ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
        e.rel     = 3'($urandom_range(0, 7));
        e.actions = ($urandom_range(0, 5) == 0) ? 10'd0 :
                    (extremes ? 10'($urandom) : 10'($urandom_range(0, 40)));
        e.last    = last;
        return e;
    endfunction

    task automatic send_set(input int n, input bit gaps, input bit extremes);
        for (int i = 0; i < n; i++) send_entry(rand_entry(i == n - 1, extremes), gaps);
    endtask

    initial begin : main
        t_entry e;
        int sent, n;
        sb = new();
        sb.cfg.max_kept = 32; sb.cfg.keep_structural = 1; sb.cfg.min_weight = 0;
        sb.cfg.min_quality = 0; sb.cfg.long_action_limit = 22;
        sb.ovf_seen = 0; sb.errors = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: a small cap forces pruning over field extremes
        reg_write(REG_MAX_KEPT, 3);
        e = '{16'sh7fff, 1, 16'sh7fff, 3'd7, 10'd1023, 0}; send_entry(e, 0);
        e = '{16'sh8000, 1, 16'sh8000, 3'd0, 10'd0, 0};    send_entry(e, 0);
        e = '{16'sd0, 0, 16'sd0, 3'd4, 10'd0, 0};         send_entry(e, 0);
        e = '{16'sd100, 1, 16'sd300, 3'd3, 10'd23, 0};    send_entry(e, 0);
        e = '{16'sd100, 1, 16'sd300, 3'd3, 10'd22, 0};    send_entry(e, 0);
        e = '{16'sd100, 1, -16'sd5, 3'd5, 10'd5, 0};       send_entry(e, 0);
        e = '{-16'sd3, 0, 16'sd0, 3'd2, 10'd5, 0};         send_entry(e, 0);
        e = '{16'sd50, 0, 16'sd0, 3'd1, 10'd0, 1};         send_entry(e, 0);
        // set within the cap, single-entry set
        reg_write(REG_MAX_KEPT, 64);
        send_set(4, 0, 1);
        e = '{16'sd1, 1, 16'sd1, 3'd6, 10'd1, 1};          send_entry(e, 0);
        drain();
        sent = 13;

        // overflow: 66 entries, no pruning at cap 64, then pruned overflow
        send_set(66, 1, 1);
        drain();
        reg_write(REG_KEEP_STRUCT, 0);
        reg_write(REG_MAX_KEPT, 0);
        send_set(65, 0, 1);
        drain();
        sent += 131;

        // long receiver stall while the sender keeps offering
        reg_write(REG_MAX_KEPT, 5);
        hold_off = 300;
        send_set(20, 0, 0);
        send_set(10, 0, 0);
        drain();
        sent += 30;

        while (sent < 460) begin
            case ($urandom_range(0, 5))
                0: reg_write(REG_MAX_KEPT, $urandom_range(0, 1) ? $urandom_range(0, 12)
                                                                : 127);
                1: reg_write(REG_KEEP_STRUCT, $urandom_range(0, 1));
                2: reg_write(REG_MIN_WEIGHT, $urandom_range(0, 3) == 0 ? $urandom
                                                : $urandom_range(0, 600) - 300);
                3: reg_write(REG_MIN_QUALITY, $urandom_range(0, 3) == 0 ? $urandom
                                                : $urandom_range(0, 600) - 300);
                4: reg_write(REG_LONG_LIMIT, $urandom_range(0, 3) == 0 ? $urandom
                                                : $urandom_range(0, 30));
                default: ;
            endcase
            sink_random = $urandom_range(0, 4) != 0;
            n = $urandom_range(1, 16);
            send_set(n, $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0);
            sent += n;
            if ($urandom_range(0, 3) == 0) drain();
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[scored_entry_pruner_core] OK");
        else
            $display("[scored_entry_pruner_core] ERROR");
        $finish;
    end
endmodule
